### rtl/core/txdb_pkg.sv
// ----------------------------------------------------------------------------
// Transmit descriptor builder package
// Shared types, constants and descriptor word encoding for the builder.
// ----------------------------------------------------------------------------
package txdb_pkg;

  // Default descriptor size in bytes.
  localparam int DESC_BYTES_DEFAULT = 40;

  // Depth of the queue between the request checker and the word emitter.
  localparam int QUEUE_DEPTH = 2;

  // Request checks.
  localparam logic [15:0] MIN_FRAME_LEN      = 16'd24;
  localparam logic [15:0] MAX_FRAME_RESET    = 16'd2304;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_RADIO_READY = 1'b0,
    REG_LEN_LIMIT   = 1'b1
  } reg_index_t;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_INVALID   = 2'd1,
    STATUS_NO_SPACE  = 2'd2,
    STATUS_UNUSED    = 2'd3
  } status_t;

  // Input transaction.
  typedef struct packed {
    logic [15:0] frame_len;
    logic [16:0] capacity;
    logic        encrypted;
    logic [7:0]  mac_id;
    logic [15:0] cookie;
    logic [7:0]  first_address_byte;
  } req_t;

  // Output transaction.
  typedef struct packed {
    logic [5:0]  word_index;
    logic [31:0] word_value;
    logic [16:0] total_length;
    status_t     status;
    logic        last;
  } desc_t;

  // Classified request as it travels from the checker to the emitter.
  typedef struct packed {
    status_t     status;
    logic [15:0] flen;
    logic [16:0] total;
    logic        enc;
    logic [6:0]  mac;
    logic [11:0] cookie;
    logic        group;
    logic [15:0] csum;
  } rec_t;

  // Value of one descriptor word for an accepted request.
  function automatic logic [31:0] desc_word(rec_t r, logic [7:0] db, logic [5:0] idx);
    logic [31:0] w;
    w = 32'd0;
    case (idx)
      6'd0: w = {1'b1, 4'd0, 1'b1, 1'b0, r.group, db, r.flen};
      6'd1: w = {8'd0, (r.enc ? 2'd3 : 2'd0), 6'd6, 9'd0, r.mac};
      6'd2: w = 32'h0008_0000;
      6'd3: w = 32'h0000_0500;
      6'd4: w = 32'h0000_0004;
      6'd6: w = {20'd0, r.cookie};
      6'd7: w = {16'd0, r.csum};
      6'd8: w = 32'h0000_8000;
      default: w = 32'd0;
    endcase
    return w;
  endfunction

  // Checksum over the first sixteen halfwords; words five and seven count as zero.
  function automatic logic [15:0] desc_csum(rec_t r, logic [7:0] db);
    logic [31:0] x;
    x = desc_word(r, db, 6'd0) ^ desc_word(r, db, 6'd1) ^ desc_word(r, db, 6'd2) ^
        desc_word(r, db, 6'd3) ^ desc_word(r, db, 6'd4) ^ desc_word(r, db, 6'd6);
    return x[15:0] ^ x[31:16];
  endfunction

endpackage

### rtl/core/txdb_front.sv
// ----------------------------------------------------------------------------
// Request checker
// Holds the configuration registers, validates each request, works out the
// wire length and checksum, and pushes a classified record into the queue.
// ----------------------------------------------------------------------------
module txdb_front #(
  parameter int DESC_BYTES = txdb_pkg::DESC_BYTES_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [15:0]    cfg_data,
  input  logic           req_valid,
  input  txdb_pkg::req_t req,
  input  logic           full,
  output logic           push,
  output txdb_pkg::rec_t rec
);
  import txdb_pkg::*;

  localparam logic [7:0]  DB8  = 8'(DESC_BYTES);
  localparam logic [16:0] DB17 = 17'(DESC_BYTES);

  logic        radio_ready;
  logic [15:0] len_limit;
  logic        bad_req;
  logic [16:0] raw_total;
  logic [16:0] total;
  rec_t        base;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      radio_ready <= 1'b0;
      len_limit   <= MAX_FRAME_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_RADIO_READY: radio_ready <= cfg_data[0];
        REG_LEN_LIMIT:   len_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Request validity checks.
  assign bad_req = !radio_ready || (req.frame_len < MIN_FRAME_LEN) ||
                   (req.frame_len > len_limit) || req.mac_id[7] ||
                   (req.cookie[15:12] != 4'd0);

  // Wire length, with a pad byte when it falls on a 512-byte boundary.
  assign raw_total = DB17 + {1'b0, req.frame_len};
  assign total     = (raw_total[8:0] == 9'd0) ? raw_total + 17'd1 : raw_total;

  // Classified record.
  always_comb begin
    base.status = STATUS_OK;
    base.flen   = req.frame_len;
    base.total  = total;
    base.enc    = req.encrypted;
    base.mac    = req.mac_id[6:0];
    base.cookie = req.cookie[11:0];
    base.group  = req.first_address_byte[0];
    base.csum   = 16'd0;

    rec      = base;
    rec.csum = desc_csum(base, DB8);
    if (bad_req) begin
      rec.status = STATUS_INVALID;
      rec.total  = 17'd0;
    end else if (req.capacity < total) begin
      rec.status = STATUS_NO_SPACE;
      rec.total  = 17'd0;
    end
  end

  assign push = req_valid && !full;

endmodule

### rtl/core/txdb_queue.sv
// ----------------------------------------------------------------------------
// Request queue
// Short first-in first-out buffer of classified records between the checker
// and the word emitter.
// ----------------------------------------------------------------------------
module txdb_queue #(
  parameter int DEPTH = txdb_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  txdb_pkg::rec_t wdata,
  input  logic           pop,
  output txdb_pkg::rec_t rdata,
  output logic           full,
  output logic           nonempty
);
  import txdb_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  rec_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

  assign rdata    = entries[rd_ptr];
  assign full     = (count == CW'(DEPTH));
  assign nonempty = (count != '0);

  // The fill count never passes the depth.
  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("queue count exceeds depth");

  // Nothing is taken from an empty queue.
  assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("pop from empty queue");

  // A push into a full queue never happens.
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");

endmodule

### rtl/core/txdb_back.sv
// ----------------------------------------------------------------------------
// Descriptor word emitter
// Takes classified records from the queue and sends one descriptor word per
// cycle unless stalled, through a registered output, or a single status transaction.
// ----------------------------------------------------------------------------
module txdb_back #(
  parameter int DESC_BYTES = txdb_pkg::DESC_BYTES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_nonempty,
  input  txdb_pkg::rec_t  q_data,
  output logic            pop,
  output logic            desc_valid,
  input  logic            desc_stall,
  output txdb_pkg::desc_t desc
);
  import txdb_pkg::*;

  localparam logic [7:0] DB8      = 8'(DESC_BYTES);
  localparam logic [5:0] LAST_IDX = 6'(DESC_BYTES / 4 - 1);

  rec_t       cur;
  logic       busy;
  logic [5:0] widx;
  logic       load;
  logic       cur_err;
  logic       last_word;
  desc_t      word_next;

  assign load      = !desc_valid || !desc_stall;
  assign cur_err   = (cur.status != STATUS_OK);
  assign last_word = cur_err || (widx == LAST_IDX);
  assign pop       = q_nonempty && (!busy || (load && last_word));

  // Next output transaction from the current record.
  always_comb begin
    word_next.word_index   = cur_err ? 6'd0 : widx;
    word_next.word_value   = cur_err ? 32'd0 : desc_word(cur, DB8, widx);
    word_next.total_length = cur.total;
    word_next.status       = cur.status;
    word_next.last         = last_word;
  end

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      desc_valid <= 1'b0;
      widx       <= 6'd0;
    end else begin
      if (load) begin
        desc_valid <= busy;
      end
      if (pop) begin
        busy <= 1'b1;
        widx <= 6'd0;
      end else if (load && busy) begin
        widx <= widx + 6'd1;
        if (last_word) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Current record and output word register.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_data;
    end
    if (load && busy) begin
      desc <= word_next;
    end
  end

  // A rejected request gives one final transaction at word zero.
  assert property (@(posedge clk) disable iff (rst)
      desc_valid && (desc.status != STATUS_OK) |-> desc.last && (desc.word_index == 6'd0))
    else $error("error result is not a single final transaction");

  // An accepted request ends exactly at its last descriptor word.
  assert property (@(posedge clk) disable iff (rst)
      desc_valid && (desc.status == STATUS_OK) |-> (desc.last == (desc.word_index == LAST_IDX)))
    else $error("last flag out of place");

  // Words of one descriptor follow each other without a gap.
  assert property (@(posedge clk) disable iff (rst)
      desc_valid && !desc_stall && !desc.last |=>
        desc_valid && (desc.word_index == $past(desc.word_index) + 6'd1))
    else $error("descriptor words not consecutive");

endmodule

### rtl/core/tx_descriptor_builder.sv
// ----------------------------------------------------------------------------
// Transmit descriptor builder
// Checks frame requests and emits transmit descriptors word by word.
// ----------------------------------------------------------------------------
// Each accepted request yields DESC_BYTES/4 output transactions, one
// descriptor word per cycle in index order unless stalled (ten at the default
// size of 40 bytes); a rejected request or one with too little buffer space
// yields a single status transaction. The rate is set by the output word
// register, which sends one word per cycle unless stalled. A two-entry queue
// sits between the request checker and the word emitter, so new requests are
// taken while a descriptor is still going out. Configuration is written
// through cfg_we, cfg_index and cfg_data; index 0 is the radio ready flag,
// index 1 is the largest accepted frame length. No clearing pass follows reset.
module tx_descriptor_builder #(
  parameter int DESC_BYTES = txdb_pkg::DESC_BYTES_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [0:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic            req_valid,
  output logic            req_stall,
  input  txdb_pkg::req_t  req,
  output logic            desc_valid,
  input  logic            desc_stall,
  output txdb_pkg::desc_t desc
);
  import txdb_pkg::*;

  logic push;
  logic pop;
  logic full;
  logic nonempty;
  rec_t rec_in;
  rec_t rec_out;

  assign req_stall = full;

  // Request checking.
  txdb_front #(
    .DESC_BYTES(DESC_BYTES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req_valid (req_valid),
    .req       (req),
    .full      (full),
    .push      (push),
    .rec       (rec_in)
  );

  // Queue between checker and emitter.
  txdb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wdata    (rec_in),
    .pop      (pop),
    .rdata    (rec_out),
    .full     (full),
    .nonempty (nonempty)
  );

  // Word emission.
  txdb_back #(
    .DESC_BYTES(DESC_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (nonempty),
    .q_data     (rec_out),
    .pop        (pop),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc       (desc)
  );

endmodule
